// ----- design/odbp_pkg.sv -----
// Package: threshold table, widths and shared types for the ordered-dither bit packer.
`default_nettype none

package odbp_pkg;

    localparam int PIX_W = 8;
    localparam int PHASE_W = 4;
    localparam int BYTE_W = 8;
    localparam int POS_W = 3;

    localparam logic [POS_W-1:0] LAST_POS = 3'd7;
    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic  emit;
        logic  eol;
        byte_t acc;
    } pack_t;

    localparam byte_t THR_TABLE [16][16] = '{
        '{8'd111, 8'd49, 8'd142, 8'd162, 8'd113, 8'd195, 8'd71, 8'd177,
          8'd201, 8'd50, 8'd151, 8'd94, 8'd66, 8'd37, 8'd85, 8'd252},
        '{8'd25, 8'd99, 8'd239, 8'd222, 8'd32, 8'd250, 8'd148, 8'd19,
          8'd38, 8'd106, 8'd220, 8'd170, 8'd194, 8'd138, 8'd13, 8'd167},
        '{8'd125, 8'd178, 8'd79, 8'd15, 8'd65, 8'd173, 8'd123, 8'd87,
          8'd213, 8'd131, 8'd247, 8'd23, 8'd116, 8'd54, 8'd229, 8'd212},
        '{8'd41, 8'd202, 8'd152, 8'd132, 8'd189, 8'd104, 8'd53, 8'd236,
          8'd161, 8'd62, 8'd1, 8'd181, 8'd77, 8'd241, 8'd147, 8'd68},
        '{8'd2, 8'd244, 8'd56, 8'd91, 8'd230, 8'd5, 8'd204, 8'd28,
          8'd187, 8'd101, 8'd144, 8'd206, 8'd33, 8'd92, 8'd190, 8'd107},
        '{8'd223, 8'd164, 8'd114, 8'd36, 8'd214, 8'd156, 8'd139, 8'd70,
          8'd245, 8'd84, 8'd226, 8'd48, 8'd126, 8'd158, 8'd17, 8'd135},
        '{8'd83, 8'd196, 8'd21, 8'd254, 8'd76, 8'd45, 8'd179, 8'd115,
          8'd12, 8'd40, 8'd169, 8'd105, 8'd253, 8'd176, 8'd211, 8'd59},
        '{8'd100, 8'd180, 8'd145, 8'd122, 8'd172, 8'd97, 8'd235, 8'd129,
          8'd215, 8'd149, 8'd199, 8'd8, 8'd72, 8'd26, 8'd238, 8'd44},
        '{8'd232, 8'd31, 8'd69, 8'd11, 8'd205, 8'd58, 8'd18, 8'd193,
          8'd88, 8'd60, 8'd112, 8'd221, 8'd140, 8'd86, 8'd120, 8'd153},
        '{8'd208, 8'd130, 8'd243, 8'd160, 8'd224, 8'd110, 8'd34, 8'd248,
          8'd165, 8'd24, 8'd234, 8'd184, 8'd52, 8'd198, 8'd171, 8'd6},
        '{8'd108, 8'd188, 8'd51, 8'd89, 8'd137, 8'd186, 8'd154, 8'd78,
          8'd47, 8'd134, 8'd98, 8'd157, 8'd35, 8'd249, 8'd95, 8'd63},
        '{8'd16, 8'd75, 8'd219, 8'd39, 8'd0, 8'd67, 8'd228, 8'd121,
          8'd197, 8'd240, 8'd3, 8'd74, 8'd127, 8'd20, 8'd227, 8'd143},
        '{8'd246, 8'd175, 8'd119, 8'd200, 8'd251, 8'd103, 8'd146, 8'd14,
          8'd209, 8'd174, 8'd109, 8'd218, 8'd192, 8'd82, 8'd203, 8'd163},
        '{8'd29, 8'd93, 8'd150, 8'd22, 8'd166, 8'd182, 8'd55, 8'd30,
          8'd90, 8'd64, 8'd42, 8'd141, 8'd168, 8'd57, 8'd117, 8'd46},
        '{8'd216, 8'd233, 8'd61, 8'd128, 8'd81, 8'd237, 8'd217, 8'd118,
          8'd159, 8'd255, 8'd185, 8'd27, 8'd242, 8'd102, 8'd4, 8'd133},
        '{8'd73, 8'd191, 8'd9, 8'd210, 8'd43, 8'd96, 8'd7, 8'd136,
          8'd231, 8'd80, 8'd10, 8'd124, 8'd225, 8'd207, 8'd155, 8'd183}
    };

endpackage

`default_nettype wire

// ----- design/odbp_if.sv -----
// Interfaces: pixel, packed byte and configuration channels.
`default_nettype none

interface odbp_pix_if;
    logic                  valid;
    logic                  ready;
    odbp_pkg::pix_t        pixel;
    odbp_pkg::phase_t      row_phase;
    logic                  line_end;

    modport source (output valid, output pixel, output row_phase, output line_end,
                    input ready);
    modport sink (input valid, input pixel, input row_phase, input line_end,
                  output ready);
endinterface

interface odbp_byte_if;
    logic                  valid;
    logic                  ready;
    odbp_pkg::byte_t       packed_byte;
    logic                  last_of_line;

    modport source (output valid, output packed_byte, output last_of_line, input ready);
    modport sink (input valid, input packed_byte, input last_of_line, output ready);
endinterface

interface odbp_cfg_if;
    logic valid;
    logic ready;
    logic invert_polarity;

    modport source (output valid, output invert_polarity, input ready);
    modport sink (input valid, input invert_polarity, output ready);
endinterface

`default_nettype wire

// ----- design/odbp_decide.sv -----
// Threshold compare and MSB-first bit packing for one pixel.
`default_nettype none

module odbp_decide (
    input  wire odbp_pkg::pix_t   pixel,
    input  wire odbp_pkg::phase_t row_phase,
    input  wire odbp_pkg::phase_t column_phase,
    input  wire odbp_pkg::byte_t  acc,
    input  wire logic             line_end,
    input  wire logic             invert_polarity,
    output odbp_pkg::pack_t       result
);

    odbp_pkg::byte_t                thresh;
    logic [odbp_pkg::POS_W-1:0]     pos;
    logic                           hit;

    always_comb
    begin
        thresh = odbp_pkg::THR_TABLE[row_phase][column_phase];
        pos    = column_phase[odbp_pkg::POS_W-1:0];
        hit    = invert_polarity ? (pixel < thresh) : (pixel >= thresh);
        result.acc  = acc | (hit ? (odbp_pkg::MSB_MASK >> pos) : '0);
        result.eol  = line_end;
        result.emit = (pos == odbp_pkg::LAST_POS) || line_end;
    end

endmodule

`default_nettype wire

// ----- design/ordered_dither_bit_packer.sv -----
// Top level: ordered-dither halftoner with byte packer.
//
//   channel   dir   payload                          handshake
//   pixels    in    pixel[7:0] row_phase[3:0] line_end valid/ready
//   bytes     out   packed_byte[7:0] last_of_line     valid/ready
//   cfg       in    invert_polarity                  valid/ready (ready tied high)
//
// One pixel per clock sustained unless a stalled byte output holds the input stage.
// Pixel input register feeds the table compare, which feeds the byte output register.
// Reset clears column phase, accumulator, polarity and both valid flags.
// A stalled byte holds the input stage only when that pixel would emit a byte.
`default_nettype none

module ordered_dither_bit_packer (
    input  wire logic clk,
    input  wire logic rst_n,
    odbp_pix_if.sink  pixels,
    odbp_byte_if.source bytes,
    odbp_cfg_if.sink  cfg
);

    logic                   s1_valid_reg;
    odbp_pkg::pix_t         s1_pixel_reg;
    odbp_pkg::phase_t       s1_row_reg;
    logic                   s1_eol_reg;

    odbp_pkg::phase_t       col_reg;
    odbp_pkg::byte_t        acc_reg;
    logic                   invert_reg;

    logic                   out_valid_reg;
    odbp_pkg::byte_t        out_byte_reg;
    logic                   out_last_reg;

    odbp_pkg::pack_t        pk;
    logic                   out_free;
    logic                   s1_fire;
    logic                   in_fire;

    odbp_decide u_decide (
        .pixel           (s1_pixel_reg),
        .row_phase       (s1_row_reg),
        .column_phase    (col_reg),
        .acc             (acc_reg),
        .line_end        (s1_eol_reg),
        .invert_polarity (invert_reg),
        .result          (pk)
    );

    assign out_free     = !out_valid_reg || bytes.ready;
    assign s1_fire      = s1_valid_reg && (!pk.emit || out_free);
    assign pixels.ready = !s1_valid_reg || s1_fire;
    assign in_fire      = pixels.valid && pixels.ready;
    assign cfg.ready    = 1'b1;

    assign bytes.valid        = out_valid_reg;
    assign bytes.packed_byte  = out_byte_reg;
    assign bytes.last_of_line = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            acc_reg       <= '0;
            invert_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                invert_reg <= cfg.invert_polarity;
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                col_reg <= pk.eol ? '0 : col_reg + odbp_pkg::phase_t'(1);
                acc_reg <= pk.emit ? '0 : pk.acc;
            end

            if (s1_fire && pk.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (bytes.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= pixels.pixel;
            s1_row_reg   <= pixels.row_phase;
            s1_eol_reg   <= pixels.line_end;
        end
        if (s1_fire && pk.emit)
        begin
            out_byte_reg <= pk.acc;
            out_last_reg <= pk.eol;
        end
    end

endmodule

`default_nettype wire

// ----- dv/odbp_checker.sv -----
`timescale 1ns / 1ps
// Checker: predicts halftone bytes from the pixel and config channels and compares them.

module odbp_checker (
    input  logic        clk,
    input  logic        rst_n,
    odbp_pix_if         pixels,
    odbp_byte_if        bytes,
    odbp_cfg_if         cfg,
    output int          bytes_owed,
    output int          mismatches
);

    typedef struct {
        odbp_pkg::byte_t packed_byte;
        logic            last_of_line;
    } byte_beat_t;

    byte_beat_t        bytes_due[$];
    logic              gray_mode;
    odbp_pkg::phase_t  column;
    odbp_pkg::byte_t   acc_bits;
    int                errors;

    function void dither_pixel(input odbp_pkg::pix_t pix, input odbp_pkg::phase_t row,
                               input logic eol);
        logic [odbp_pkg::POS_W-1:0] pos;
        logic                       hit;
        byte_beat_t                 beat;
        pos = column[odbp_pkg::POS_W-1:0];
        if (gray_mode)
            hit = pix < odbp_pkg::THR_TABLE[row][column];
        else
            hit = pix >= odbp_pkg::THR_TABLE[row][column];
        if (hit)
            acc_bits = acc_bits | (odbp_pkg::MSB_MASK >> pos);
        if (pos == odbp_pkg::LAST_POS || eol)
        begin
            beat.packed_byte = acc_bits;
            beat.last_of_line = eol;
            bytes_due.push_back(beat);
            acc_bits = '0;
        end
        column = eol ? odbp_pkg::phase_t'(0) : odbp_pkg::phase_t'(column + 1'b1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        byte_beat_t want;
        if (!rst_n)
        begin
            gray_mode = 1'b0;
            column = '0;
            acc_bits = '0;
            bytes_due.delete();
            errors = 0;
            bytes_owed <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                gray_mode = cfg.invert_polarity;
            if (bytes.valid && bytes.ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("unexpected byte beat: packed_byte %02h last_of_line %0b",
                           bytes.packed_byte, bytes.last_of_line);
                    errors++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (bytes.packed_byte !== want.packed_byte)
                    begin
                        $error("packed_byte: expected %02h, actual %02h",
                               want.packed_byte, bytes.packed_byte);
                        errors++;
                    end
                    if (bytes.last_of_line !== want.last_of_line)
                    begin
                        $error("last_of_line: expected %0b, actual %0b",
                               want.last_of_line, bytes.last_of_line);
                        errors++;
                    end
                end
            end
            if (pixels.valid && pixels.ready)
                dither_pixel(pixels.pixel, pixels.row_phase, pixels.line_end);
            bytes_owed <= bytes_due.size();
            mismatches <= errors;
        end
    end

endmodule

// ----- dv/ordered_dither_bit_packer_test.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, pixel and config stimulus, byte sink and verdict.

module ordered_dither_bit_packer_test;

    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;

    logic clk;
    logic rst_n;
    logic steady;
    logic sender_calm;
    int   bytes_owed;
    int   mismatches;
    int   idle_cycles;
    int   line_no;
    int   items_sent;

    odbp_pix_if  pixels ();
    odbp_byte_if bytes ();
    odbp_cfg_if  cfg ();

    ordered_dither_bit_packer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .bytes  (bytes),
        .cfg    (cfg)
    );

    odbp_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .bytes      (bytes),
        .cfg        (cfg),
        .bytes_owed (bytes_owed),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // byte sink: random stall bursts unless steady
    initial
    begin
        int stall;
        bytes.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 7);
                bytes.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                bytes.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixels.valid && pixels.ready) || (bytes.valid && bytes.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_pixel(input odbp_pkg::pix_t pix, input odbp_pkg::phase_t row,
                              input logic eol);
        int gap;
        if (!steady && !sender_calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 7);
            repeat (gap)
            begin
                @(negedge clk);
                pixels.valid = 1'b0;
            end
        end
        @(negedge clk);
        pixels.valid = 1'b1;
        pixels.pixel = pix;
        pixels.row_phase = row;
        pixels.line_end = eol;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // drains the pipe before touching the register
    task automatic write_polarity(input logic gray);
        @(negedge clk);
        pixels.valid = 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.invert_polarity = gray;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_line(input int len, input bit noisy);
        odbp_pkg::pix_t   pix;
        odbp_pkg::phase_t row;
        row = odbp_pkg::phase_t'(line_no);
        sender_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                row = odbp_pkg::phase_t'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0)
                pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                pix = odbp_pkg::pix_t'($urandom_range(0, 255));
            push_pixel(pix, row, i == len - 1);
        end
        line_no++;
    endtask

    initial
    begin
        int   phase_end;
        int   len;
        logic gray;
        rst_n = 1'b0;
        steady = 1'b0;
        sender_calm = 1'b0;
        line_no = 0;
        items_sent = 0;
        pixels.valid = 1'b0;
        pixels.pixel = '0;
        pixels.row_phase = '0;
        pixels.line_end = 1'b0;
        cfg.valid = 1'b0;
        cfg.invert_polarity = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // black mode from reset; line closes exactly on a byte boundary
        push_pixel(8'hFF, 4'd0, 1'b0);
        push_pixel(8'h00, 4'd0, 1'b0);
        push_pixel(8'hFF, 4'd0, 1'b0);
        push_pixel(8'h00, 4'd0, 1'b0);
        push_pixel(8'h00, 4'd0, 1'b0);
        push_pixel(8'hFF, 4'd0, 1'b0);
        push_pixel(8'd71, 4'd0, 1'b0);
        push_pixel(8'd176, 4'd0, 1'b1);
        // partial byte, last table row
        push_pixel(8'h00, 4'd15, 1'b0);
        push_pixel(8'hFF, 4'd15, 1'b0);
        push_pixel(8'd128, 4'd15, 1'b1);
        // one-pixel line
        push_pixel(8'hFF, 4'd7, 1'b1);
        // gray mode: full byte inside the line, then one-bit tail
        write_polarity(1'b1);
        push_pixel(8'h00, 4'd10, 1'b0);
        push_pixel(8'hFF, 4'd10, 1'b0);
        push_pixel(8'h00, 4'd10, 1'b0);
        push_pixel(8'hFF, 4'd10, 1'b0);
        push_pixel(8'd254, 4'd10, 1'b0);
        push_pixel(8'd1, 4'd10, 1'b0);
        push_pixel(8'd154, 4'd10, 1'b0);
        push_pixel(8'd77, 4'd10, 1'b0);
        push_pixel(8'h00, 4'd10, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            gray = p[0];
            write_polarity(gray);
            if (p == 3)
                steady = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(17, 40);
                else
                    len = $urandom_range(1, 16);
                send_line(len, $urandom_range(0, 7) == 0);
            end
        end

        @(negedge clk);
        pixels.valid = 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
